[hw/rtl/bpa_pkg.sv]
// Shared types, constants and helper functions for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int PAGES      = 4096;
  localparam int PAGE_W     = 12;
  localparam int CNT_W      = 13;
  localparam int TOP_ORDER  = 9;
  localparam int NUM_LISTS  = TOP_ORDER + 1;
  localparam int ORD_W      = 4;
  localparam int MAP_W      = 32;
  localparam int MAP_SH     = 5;
  localparam int MAP_DEPTH  = PAGES / MAP_W;
  localparam int MAP_AW     = PAGE_W - MAP_SH;
  localparam logic [CNT_W-1:0] NO_PAGE = CNT_W'(PAGES);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] page_index;
    logic [12:0] end_page;
    logic [9:0]  page_count;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] block_page;
    logic [3:0]  block_order;
    logic [12:0] free_page_total;
    logic [12:0] managed_page_total;
  } rsp_item_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_MAP_RD,
    S_MAP_WR,
    S_ADD_PUSH,
    S_ALLOC_RD,
    S_ALLOC_POP,
    S_SPLIT,
    S_MERGE,
    S_CHK_RD,
    S_CHK_EVAL,
    S_WALK_CHK,
    S_WALK_EVAL,
    S_PUSH_FINAL,
    S_REPLY
  } state_t;

  // Block size in pages for a given order.
  function automatic logic [CNT_W-1:0] pow2(input logic [ORD_W-1:0] o);
    return CNT_W'(1) << o;
  endfunction

  // Smallest order whose block holds count pages; TOP_ORDER+1 when too large.
  function automatic logic [ORD_W-1:0] order_of(input logic [9:0] count);
    logic [ORD_W-1:0] o;
    o = '0;
    for (int k = 0; k <= TOP_ORDER; k++) begin
      if ({1'b0, count} > (11'(1) << k)) o = ORD_W'(k + 1);
    end
    return o;
  endfunction

  // Largest aligned block starting at pg that stays below lim.
  function automatic logic [ORD_W-1:0] add_order(input logic [CNT_W-1:0] pg,
                                                  input logic [CNT_W-1:0] lim);
    logic [ORD_W-1:0] o;
    logic             run;
    logic [CNT_W:0]   top;
    logic [CNT_W-1:0] low;
    o   = '0;
    run = 1'b1;
    for (int k = 1; k <= TOP_ORDER; k++) begin
      low = (CNT_W'(1) << k) - CNT_W'(1);
      top = {1'b0, pg} + ((CNT_W + 1)'(1) << k);
      if (run && ((pg & low) == '0) && (top <= {1'b0, lim})) o = ORD_W'(k);
      else run = 1'b0;
    end
    return o;
  endfunction

  // Bits of bitmap word wd whose pages lie in [lo, hi).
  function automatic logic [MAP_W-1:0] range_mask(input logic [MAP_AW-1:0] wd,
                                                   input logic [CNT_W-1:0] lo,
                                                   input logic [CNT_W-1:0] hi);
    logic [MAP_W-1:0] m;
    logic [CNT_W-1:0] p;
    m = '0;
    for (int b = 0; b < MAP_W; b++) begin
      p    = {1'b0, wd, MAP_SH'(b)};
      m[b] = (p >= lo) && (p < hi);
    end
    return m;
  endfunction

endpackage

[hw/rtl/bpa_link_ram.sv]
// Next-link memory of the free lists, one entry per page.
`timescale 1ns / 1ps
module bpa_link_ram import bpa_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [PAGE_W-1:0] waddr,
  input  logic [CNT_W-1:0]  wdata,
  input  logic [PAGE_W-1:0] raddr,
  output logic [CNT_W-1:0]  rdata
);

  logic [CNT_W-1:0] mem [PAGES];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bpa_map_ram.sv]
// Used-page bitmap memory, one word of pages per entry.
`timescale 1ns / 1ps
module bpa_map_ram import bpa_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [MAP_AW-1:0] waddr,
  input  logic [MAP_W-1:0]  wdata,
  input  logic [MAP_AW-1:0] raddr,
  output logic [MAP_W-1:0]  rdata
);

  logic [MAP_W-1:0] mem [MAP_DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bpa_core.sv]
// Command sequencer: walks the free lists and bitmap memories for one command.
`timescale 1ns / 1ps
module bpa_core import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_item_t req,
  input  logic      req_valid,
  output logic      req_ready,
  output rsp_item_t res,
  output logic      res_valid,
  input  logic      res_ready
);

  state_t state, state_next;

  logic [1:0]        c_cmd;
  logic [11:0]       c_page;
  logic [12:0]       c_end;
  logic [9:0]        c_count;
  logic [CNT_W-1:0]  pg, end_q, rng_lo, rng_hi, cur, prev, step;
  logic [ORD_W-1:0]  ord, want, out_ord;
  logic [PAGE_W-1:0] blk, bud, out_blk;
  logic [MAP_AW-1:0] wd, wd_last, init_cnt;
  logic              set_val;
  logic [1:0]        status_q;
  logic [CNT_W-1:0]  highest, managed, used;
  logic [CNT_W-1:0]  heads [NUM_LISTS];

  logic              link_we;
  logic [PAGE_W-1:0] link_waddr, link_raddr;
  logic [CNT_W-1:0]  link_wdata, link_rdata;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;

  logic [CNT_W-1:0]  end_clamp, add_last, n_req, free_end, free_last;
  logic [ORD_W-1:0]  req_ord, found, ao, hidx, ord_dn;
  logic              ord_ok, hit;
  logic [CNT_W-1:0]  size, bud_end, bud_last, split_pg, alloc_top, alloc_last;
  logic [CNT_W:0]    alloc_sum, used_sum, man_sum;
  logic [PAGE_W-1:0] buddy_c;
  logic [MAP_W-1:0]  mask;
  logic [CNT_W-1:0]  head_rd, nxt;

  bpa_link_ram u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  bpa_map_ram u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // Request decode and shared address arithmetic.
  always_comb begin
    end_clamp = (c_end > NO_PAGE) ? NO_PAGE : c_end;
    add_last  = end_clamp - CNT_W'(1);
    req_ord   = order_of(c_count);
    ord_ok    = (req_ord <= ORD_W'(TOP_ORDER));
    n_req     = pow2(req_ord);
    free_end  = {1'b0, c_page} + n_req;
    free_last = free_end - CNT_W'(1);
    ao        = add_order(pg, end_q);
    ord_dn    = ord - ORD_W'(1);
    size      = pow2(ord);
    buddy_c   = pg[PAGE_W-1:0] ^ size[PAGE_W-1:0];
    bud_end   = {1'b0, buddy_c} + size;
    bud_last  = bud_end - CNT_W'(1);
    split_pg  = {1'b0, blk} + pow2(ord_dn);
    alloc_sum = {2'b0, blk} + {1'b0, pow2(want)};
    alloc_top = (alloc_sum > {1'b0, NO_PAGE}) ? NO_PAGE : alloc_sum[CNT_W-1:0];
    alloc_last = alloc_top - CNT_W'(1);
    used_sum  = {1'b0, used} + {1'b0, pow2(want)};
    man_sum   = {1'b0, managed} + {1'b0, pow2(ao)};
    mask      = range_mask(wd, rng_lo, rng_hi);
    nxt       = link_rdata[CNT_W-1] ? NO_PAGE : link_rdata;
  end

  // Lowest non-empty list at or above the requested order.
  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if ((ORD_W'(k) >= req_ord) && !heads[k][CNT_W-1]) begin
        hit   = 1'b1;
        found = ORD_W'(k);
      end
    end
  end

  // Single read port on the list heads.
  always_comb begin
    case (state)
      S_ADD_PUSH: hidx = ao;
      S_SPLIT:    hidx = ord_dn;
      default:    hidx = ord;
    endcase
    head_rd = heads[hidx];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (init_cnt == MAP_AW'(MAP_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        state_next = S_REPLY;
        case (c_cmd)
          CMD_ADD: if (end_clamp > {1'b0, c_page}) state_next = S_MAP_RD;
          CMD_ALLOC: if (c_count != '0 && ord_ok && hit) state_next = S_ALLOC_RD;
          CMD_FREE: begin
            if (c_count != '0 && ord_ok && {1'b0, c_page} < highest &&
                free_end <= NO_PAGE) state_next = S_MAP_RD;
          end
          default: state_next = S_REPLY;
        endcase
      end
      S_MAP_RD: state_next = S_MAP_WR;
      S_MAP_WR: begin
        if (wd != wd_last) state_next = S_MAP_RD;
        else if (c_cmd == CMD_ADD) state_next = S_ADD_PUSH;
        else if (c_cmd == CMD_ALLOC) state_next = S_REPLY;
        else state_next = S_MERGE;
      end
      S_ADD_PUSH: if (pg >= end_q) state_next = S_REPLY;
      S_ALLOC_RD: state_next = S_ALLOC_POP;
      S_ALLOC_POP: state_next = S_SPLIT;
      S_SPLIT: if (ord == want) state_next = S_MAP_RD;
      S_MERGE: begin
        if (ord >= ORD_W'(TOP_ORDER) || bud_end > highest) state_next = S_PUSH_FINAL;
        else state_next = S_CHK_RD;
      end
      S_CHK_RD: state_next = S_CHK_EVAL;
      S_CHK_EVAL: begin
        if ((map_rdata & mask) != '0) state_next = S_PUSH_FINAL;
        else if (wd == wd_last) state_next = S_WALK_CHK;
        else state_next = S_CHK_RD;
      end
      S_WALK_CHK: begin
        if (cur[CNT_W-1] || step > NO_PAGE) state_next = S_PUSH_FINAL;
        else state_next = S_WALK_EVAL;
      end
      S_WALK_EVAL: begin
        if (cur[PAGE_W-1:0] == bud) state_next = S_MERGE;
        else state_next = S_WALK_CHK;
      end
      S_PUSH_FINAL: state_next = S_REPLY;
      S_REPLY: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control and handshake outputs.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = '0;
    map_we     = 1'b0;
    map_waddr  = '0;
    map_wdata  = '0;
    map_raddr  = '0;
    req_ready  = (state == S_IDLE);
    res_valid  = (state == S_REPLY);
    case (state)
      S_INIT: begin
        map_we    = 1'b1;
        map_waddr = init_cnt;
        map_wdata = '1;
      end
      S_MAP_RD: map_raddr = wd;
      S_MAP_WR: begin
        map_we    = 1'b1;
        map_waddr = wd;
        map_wdata = set_val ? (map_rdata | mask) : (map_rdata & ~mask);
      end
      S_CHK_RD: map_raddr = wd;
      S_ADD_PUSH: begin
        if (pg < end_q) begin
          link_we    = 1'b1;
          link_waddr = pg[PAGE_W-1:0];
          link_wdata = head_rd;
        end
      end
      S_ALLOC_RD: link_raddr = head_rd[PAGE_W-1:0];
      S_SPLIT: begin
        if (ord != want && !split_pg[CNT_W-1]) begin
          link_we    = 1'b1;
          link_waddr = split_pg[PAGE_W-1:0];
          link_wdata = head_rd;
        end
      end
      S_WALK_CHK: link_raddr = cur[PAGE_W-1:0];
      S_WALK_EVAL: begin
        if (cur[PAGE_W-1:0] == bud && !prev[CNT_W-1]) begin
          link_we    = 1'b1;
          link_waddr = prev[PAGE_W-1:0];
          link_wdata = nxt;
        end
      end
      S_PUSH_FINAL: begin
        if (!pg[CNT_W-1]) begin
          link_we    = 1'b1;
          link_waddr = pg[PAGE_W-1:0];
          link_wdata = head_rd;
        end
      end
      default: ;
    endcase
  end

  // Control state, counters and list heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      highest  <= '0;
      managed  <= '0;
      used     <= '0;
      for (int k = 0; k < NUM_LISTS; k++) heads[k] <= NO_PAGE;
    end else begin
      state <= state_next;
      case (state)
        S_INIT: init_cnt <= init_cnt + MAP_AW'(1);
        S_DECODE: begin
          if (c_cmd == CMD_ADD && end_clamp > {1'b0, c_page} && end_clamp > highest)
            highest <= end_clamp;
          if (c_cmd == CMD_FREE && c_count != '0 && ord_ok &&
              {1'b0, c_page} < highest && free_end <= NO_PAGE)
            used <= (used > n_req) ? used - n_req : '0;
        end
        S_ADD_PUSH: begin
          if (pg < end_q) begin
            heads[hidx] <= pg;
            managed     <= (man_sum > {1'b0, NO_PAGE}) ? NO_PAGE : man_sum[CNT_W-1:0];
          end
        end
        S_ALLOC_POP: heads[hidx] <= nxt;
        S_SPLIT: begin
          if (ord != want && !split_pg[CNT_W-1]) heads[hidx] <= split_pg;
          if (ord == want)
            used <= (used_sum > {1'b0, NO_PAGE}) ? NO_PAGE : used_sum[CNT_W-1:0];
        end
        S_WALK_EVAL: begin
          if (cur[PAGE_W-1:0] == bud && prev[CNT_W-1]) heads[hidx] <= nxt;
        end
        S_PUSH_FINAL: if (!pg[CNT_W-1]) heads[hidx] <= pg;
        default: ;
      endcase
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          c_cmd   <= req.command;
          c_page  <= req.page_index;
          c_end   <= req.end_page;
          c_count <= req.page_count;
          out_blk <= '0;
          out_ord <= '0;
        end
      end
      S_DECODE: begin
        case (c_cmd)
          CMD_ADD: begin
            if (end_clamp > {1'b0, c_page}) begin
              status_q <= ST_OK;
              rng_lo   <= {1'b0, c_page};
              rng_hi   <= end_clamp;
              set_val  <= 1'b0;
              wd       <= c_page[PAGE_W-1:MAP_SH];
              wd_last  <= add_last[PAGE_W-1:MAP_SH];
              end_q    <= end_clamp;
              pg       <= {1'b0, c_page};
            end else begin
              status_q <= ST_BAD;
            end
          end
          CMD_ALLOC: begin
            if (c_count != '0 && ord_ok) begin
              want    <= req_ord;
              out_ord <= req_ord;
              ord     <= found;
              status_q <= hit ? ST_OK : ST_NOSPACE;
            end else begin
              status_q <= ST_BAD;
            end
          end
          CMD_FREE: begin
            if (c_count != '0 && ord_ok && {1'b0, c_page} < highest &&
                free_end <= NO_PAGE) begin
              status_q <= ST_OK;
              out_ord  <= req_ord;
              ord      <= req_ord;
              pg       <= {1'b0, c_page};
              rng_lo   <= {1'b0, c_page};
              rng_hi   <= free_end;
              set_val  <= 1'b0;
              wd       <= c_page[PAGE_W-1:MAP_SH];
              wd_last  <= free_last[PAGE_W-1:MAP_SH];
            end else begin
              status_q <= ST_BAD;
            end
          end
          default: status_q <= ST_BAD;
        endcase
      end
      S_MAP_WR: if (wd != wd_last) wd <= wd + MAP_AW'(1);
      S_ADD_PUSH: if (pg < end_q) pg <= pg + pow2(ao);
      S_ALLOC_RD: blk <= head_rd[PAGE_W-1:0];
      S_SPLIT: begin
        if (ord != want) begin
          ord <= ord_dn;
        end else begin
          rng_lo  <= {1'b0, blk};
          rng_hi  <= alloc_top;
          set_val <= 1'b1;
          wd      <= blk[PAGE_W-1:MAP_SH];
          wd_last <= alloc_last[PAGE_W-1:MAP_SH];
          out_blk <= blk;
        end
      end
      S_MERGE: begin
        bud     <= buddy_c;
        rng_lo  <= {1'b0, buddy_c};
        rng_hi  <= bud_end;
        wd      <= buddy_c[PAGE_W-1:MAP_SH];
        wd_last <= bud_last[PAGE_W-1:MAP_SH];
      end
      S_CHK_EVAL: begin
        wd   <= wd + MAP_AW'(1);
        cur  <= head_rd;
        prev <= NO_PAGE;
        step <= '0;
      end
      S_WALK_EVAL: begin
        if (cur[PAGE_W-1:0] == bud) begin
          if ({1'b0, bud} < pg) pg <= {1'b0, bud};
          ord <= ord + ORD_W'(1);
        end else begin
          prev <= cur;
          cur  <= nxt;
          step <= step + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Result of the finished command.
  always_comb begin
    res.status             = status_q;
    res.block_page         = out_blk;
    res.block_order        = out_ord;
    res.free_page_total    = (managed > used) ? managed - used : '0;
    res.managed_page_total = managed;
  end

endmodule

[hw/rtl/buddy_page_allocator_unit.sv]
// Top level of the buddy page allocator: sequencer plus registered result stage.
//
// Commands arrive on cmd (add region, allocate, free) under cmd_valid/cmd_stall;
// a transfer happens at a rising edge with cmd_valid high and cmd_stall low.
// Every command yields exactly one result on rsp under rsp_valid/rsp_stall.
// One command is worked on at a time; the next is taken once the result has
// moved to the output register, which may still wait on a stalled receiver.
// Latency depends on the command and is set by the bitmap and link memory
// ports: it grows with each 32-page bitmap word touched, each block pushed
// or split, and each bitmap word checked and list node walked while merging
// a freed block. After reset a pass over all 128 bitmap words sets every
// page to used, during which cmd_stall stays high; list heads and counters
// clear at once. While rsp_stall is high the result holds, and the next
// command's result waits inside the block until the output register frees.
`timescale 1ns / 1ps
module buddy_page_allocator_unit import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  logic      req_ready, res_valid, res_ready;
  rsp_item_t res;

  bpa_core u_core (
    .clk(clk), .rst(rst),
    .req(cmd), .req_valid(cmd_valid), .req_ready(req_ready),
    .res(res), .res_valid(res_valid), .res_ready(res_ready)
  );

  assign cmd_stall = !req_ready;
  assign res_ready = !rsp_valid || !rsp_stall;

  // Output register: loads when empty or when its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

[dv/tb_buddy_page_allocator_unit.sv]
// Self-checking testbench for the buddy page allocator: scoreboard class and top module.
`timescale 1ns / 1ps
import bpa_pkg::*;

// Predicts each result from its own copy of the allocator state and checks the results.
class page_alloc_scoreboard;

  int        heads[NUM_LISTS];
  int        links[PAGES];
  bit        used_map[PAGES];
  int        high_end;
  int        managed;
  int        in_use;
  rsp_item_t awaited[$];
  int        errors;
  int        checked;

  function new();
    for (int i = 0; i < NUM_LISTS; i++) heads[i] = PAGES;
    for (int i = 0; i < PAGES; i++) begin
      links[i]    = 0;
      used_map[i] = 1'b1;
    end
    high_end = 0;
    managed  = 0;
    in_use   = 0;
    errors   = 0;
    checked  = 0;
  endfunction

  // Prints one mismatch line and counts it.
  task report(string what, int got, int want);
    errors++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function int order_for(int count);
    int o;
    o = 0;
    while (o <= TOP_ORDER && (1 << o) < count) o++;
    return o;
  endfunction

  function void push_block(int o, int pg);
    if (o > TOP_ORDER || pg >= PAGES) return;
    links[pg] = heads[o];
    heads[o]  = pg;
  endfunction

  function int link_of(int pg);
    if (pg >= PAGES) return PAGES;
    return (links[pg] >= PAGES) ? PAGES : links[pg];
  endfunction

  // Removes pg from list o; the walk is bounded so that a looped list cannot hang it.
  function bit unlink_block(int o, int pg);
    int prev;
    int cur;
    prev = PAGES;
    cur  = heads[o];
    for (int steps = 0; steps <= PAGES && cur < PAGES; steps++) begin
      if (cur == pg) begin
        if (prev == PAGES) heads[o] = link_of(cur);
        else links[prev] = link_of(cur);
        return 1'b1;
      end
      prev = cur;
      cur  = link_of(cur);
    end
    return 1'b0;
  endfunction

  function void mark_range(int first, int count, bit v);
    for (int i = 0; i < count && first + i < PAGES; i++) used_map[first + i] = v;
  endfunction

  function bit range_clear(int first, int count);
    for (int i = 0; i < count; i++) begin
      if (first + i >= PAGES || used_map[first + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function status_code_t take_range(int start, int stop);
    int pg;
    int o;
    if (stop > PAGES) stop = PAGES;
    if (stop <= start) return ST_BAD;
    mark_range(start, stop - start, 1'b0);
    if (stop > high_end) high_end = stop;
    pg = start;
    while (pg < stop) begin
      o = 0;
      while (o < TOP_ORDER) begin
        if ((pg & ((1 << (o + 1)) - 1)) != 0 || pg + (1 << (o + 1)) > stop) break;
        o++;
      end
      push_block(o, pg);
      managed += 1 << o;
      if (managed > PAGES) managed = PAGES;
      pg += 1 << o;
    end
    return ST_OK;
  endfunction

  function status_code_t alloc_block(int count, output int pg, output int ord);
    int want;
    int o;
    pg  = 0;
    ord = 0;
    if (count == 0) return ST_BAD;
    want = order_for(count);
    if (want > TOP_ORDER) return ST_BAD;
    ord = want;
    for (o = want; o <= TOP_ORDER; o++) begin
      if (heads[o] < PAGES) break;
    end
    if (o > TOP_ORDER) return ST_NOSPACE;
    pg       = heads[o];
    heads[o] = link_of(pg);
    // Surplus upper halves go back onto the lower lists.
    while (o > want) begin
      o--;
      push_block(o, pg + (1 << o));
    end
    mark_range(pg, 1 << want, 1'b1);
    in_use += 1 << want;
    if (in_use > PAGES) in_use = PAGES;
    return ST_OK;
  endfunction

  function status_code_t release_pages(int pg, int count, output int ord);
    int o;
    int n;
    int buddy;
    ord = 0;
    if (count == 0) return ST_BAD;
    o = order_for(count);
    if (o > TOP_ORDER || pg >= high_end) return ST_BAD;
    n = 1 << o;
    if (pg + n > PAGES) return ST_BAD;
    ord = o;
    mark_range(pg, n, 1'b0);
    in_use = (in_use > n) ? in_use - n : 0;
    // Merge while the buddy is managed, wholly clear and on its list.
    while (o < TOP_ORDER) begin
      buddy = pg ^ (1 << o);
      if (buddy + (1 << o) > high_end) break;
      if (!range_clear(buddy, 1 << o)) break;
      if (!unlink_block(o, buddy)) break;
      if (buddy < pg) pg = buddy;
      o++;
    end
    push_block(o, pg);
    return ST_OK;
  endfunction

  // Notes an accepted command and returns the result it must produce.
  function rsp_item_t note_command(cmd_item_t c);
    rsp_item_t    r;
    status_code_t st;
    int           pg;
    int           ord;
    pg  = 0;
    ord = 0;
    case (c.command)
      CMD_ADD:   st = take_range(c.page_index, c.end_page);
      CMD_ALLOC: st = alloc_block(c.page_count, pg, ord);
      CMD_FREE:  st = release_pages(c.page_index, c.page_count, ord);
      default:   st = ST_BAD;
    endcase
    if (st == ST_BAD) begin
      pg  = 0;
      ord = 0;
    end else if (st == ST_NOSPACE) begin
      pg = 0;
    end
    r.status             = st;
    r.block_page         = PAGE_W'(pg);
    r.block_order        = ORD_W'(ord);
    r.free_page_total    = CNT_W'((managed > in_use) ? managed - in_use : 0);
    r.managed_page_total = CNT_W'(managed);
    awaited.push_back(r);
    return r;
  endfunction

  // Compares a transferred result with the oldest one awaited.
  task check_result(rsp_item_t got);
    rsp_item_t want;
    if (awaited.size() == 0) begin
      report("result with none awaited, status", got.status, -1);
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.block_page !== want.block_page)
      report("block_page", got.block_page, want.block_page);
    if (got.block_order !== want.block_order)
      report("block_order", got.block_order, want.block_order);
    if (got.free_page_total !== want.free_page_total)
      report("free_page_total", got.free_page_total, want.free_page_total);
    if (got.managed_page_total !== want.managed_page_total)
      report("managed_page_total", got.managed_page_total, want.managed_page_total);
  endtask
endclass

module tb_buddy_page_allocator_unit;
  import bpa_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 60000;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct {
    int pg;
    int count;
  } held_block_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  page_alloc_scoreboard board = new();
  held_block_t          held[$];
  held_block_t          last_freed;
  bit                   calm = 1'b0;
  int                   idle_cycles = 0;
  int                   sent[4] = '{0, 0, 0, 0};

  buddy_page_allocator_unit dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  // Signals are settled mid-cycle, so a transfer due at the next edge is seen here.
  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
    if (!rst && ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cmd_item_t make_cmd(logic [1:0] op, int pg, int stop, int count);
    cmd_item_t c;
    c.command    = op;
    c.page_index = PAGE_W'(pg);
    c.end_page   = CNT_W'(stop);
    c.page_count = 10'(count);
    return c;
  endfunction

  // Presents one command, with an optional idle gap first, and waits for its transfer.
  task automatic send(cmd_item_t c, output rsp_item_t want);
    bit taken;
    if (!calm && $urandom_range(0, 99) < 25) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 25) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do begin
      @(negedge clk);
      taken = !cmd_stall;
      if (taken) want = board.note_command(c);
      @(posedge clk);
    end while (!taken);
    sent[c.command]++;
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic alloc_and_hold(int count);
    rsp_item_t r;
    send(make_cmd(CMD_ALLOC, $urandom, $urandom, count), r);
    if (r.status == ST_OK) held.push_back('{int'(r.block_page), count});
  endtask

  task automatic free_held();
    rsp_item_t r;
    int        k;
    k          = $urandom_range(0, held.size() - 1);
    last_freed = held[k];
    held.delete(k);
    send(make_cmd(CMD_FREE, last_freed.pg, $urandom, last_freed.count), r);
  endtask

  initial begin
    rsp_item_t r;
    int        pick;
    int        start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: odd commands, empty and clamped regions, size limits, misuse.
    send(make_cmd(CMD_UNKNOWN, 12'hFFF, 13'h1FFF, 10'h3FF), r);
    send(make_cmd(CMD_ADD, 100, 40, 0), r);
    send(make_cmd(CMD_ALLOC, 0, 0, 1), r);
    send(make_cmd(CMD_FREE, 5, 0, 1), r);
    send(make_cmd(CMD_ADD, 0, 2048, 0), r);
    send(make_cmd(CMD_FREE, 3000, 0, 1), r);
    send(make_cmd(CMD_ADD, 3000, 8191, 0), r);
    send(make_cmd(CMD_ADD, 0, 64, 0), r);
    send(make_cmd(CMD_ALLOC, 0, 0, 0), r);
    send(make_cmd(CMD_ALLOC, 0, 0, 1023), r);
    send(make_cmd(CMD_ALLOC, 0, 0, 513), r);
    alloc_and_hold(512);
    alloc_and_hold(1);
    alloc_and_hold(3);
    send(make_cmd(CMD_FREE, 0, 0, 0), r);
    send(make_cmd(CMD_FREE, 4095, 0, 2), r);
    send(make_cmd(CMD_FREE, 4095, 0, 1), r);
    free_held();
    send(make_cmd(CMD_FREE, last_freed.pg, 0, last_freed.count), r);
    send(make_cmd(CMD_FREE, 1, 0, 2), r);
    while (held.size() != 0) free_held();
    send(make_cmd(CMD_ADD, 4095, 4096, 0), r);
    drain();

    // Random part: mostly allocate and release cycles, with noise and misuse mixed in.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 600 && i < 800);
      if (i == 900) drain();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        alloc_and_hold(($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 1023));
      end else if (pick < 75 && held.size() != 0) begin
        free_held();
      end else if (pick < 82) begin
        start = $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0) send(make_cmd(CMD_ADD, start, $urandom, $urandom), r);
        else send(make_cmd(CMD_ADD, start, start + $urandom_range(1, 300), $urandom), r);
      end else if (pick < 88) begin
        send(make_cmd(CMD_FREE, $urandom, $urandom, $urandom), r);
      end else if (pick < 92) begin
        send(make_cmd(CMD_UNKNOWN, $urandom, $urandom, $urandom), r);
      end else if (pick < 95 && last_freed.count != 0) begin
        send(make_cmd(CMD_FREE, last_freed.pg, $urandom, last_freed.count), r);
      end else begin
        send(make_cmd(($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE,
                      $urandom, $urandom, 0), r);
      end
    end
    calm = 1'b0;
    drain();
    repeat (64) @(posedge clk);

    $display("Covered %0d adds, %0d allocates, %0d frees and %0d unknown commands;",
             sent[0], sent[1], sent[2], sent[3]);
    $display("%0d results checked against the prediction, %0d mismatches.",
             board.checked, board.errors);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
